/* rtl/vse_pkg.sv */
// ----------------------------------------------------------------------------
// vse_pkg
// Shared constants for the von Mises-Fisher statistics estimator.
// ----------------------------------------------------------------------------
package vse_pkg;

    // Vector store geometry
    localparam int MAX_DIM = 64;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int CNT_W   = $clog2(MAX_DIM + 1);

    // Shared divider operand widths
    localparam int DIV_NW  = 64;
    localparam int DIV_DW  = 33;
    localparam int DIV_CW  = $clog2(DIV_NW + 1);

    // Square root unit widths
    localparam int ROOT_VW = 64;
    localparam int ROOT_RW = ROOT_VW / 2;
    localparam int ROOT_CW = $clog2(ROOT_RW + 1);

    // Fixed-point constants
    localparam logic [16:0] ONE_Q16      = 17'h1_0000;
    localparam logic [31:0] LIMIT_RESET  = 32'd65536000;
    localparam logic [15:0] POS_SAT      = 16'h7FFF;
    localparam logic [16:0] NEG_SAT      = 17'h0_8000;

    // Divider request from the sequencer
    typedef struct packed {
        logic                start;
        logic [DIV_NW-1:0]   dividend;
        logic [DIV_DW-1:0]   divisor;
    } div_req_t;

endpackage

/* rtl/vse_ram.sv */
// ----------------------------------------------------------------------------
// vse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/vse_root.sv */
// ----------------------------------------------------------------------------
// vse_root
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module vse_root (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [vse_pkg::ROOT_VW-1:0] value,
    output logic                        done,
    output logic [vse_pkg::ROOT_RW-1:0] root
);
    import vse_pkg::*;

    logic [ROOT_VW-1:0] val_reg;
    logic [ROOT_RW+1:0] rem_reg;
    logic [ROOT_RW-1:0] root_reg;
    logic [ROOT_CW-1:0] cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [ROOT_RW+3:0] rem_sh;
    logic [ROOT_RW+3:0] trial;
    logic               fits;

    // Bring down two bits and try the next root bit
    always_comb
    begin
        rem_sh = {rem_reg, val_reg[ROOT_VW-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                val_reg  <= value;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= ROOT_CW'(ROOT_RW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                val_reg <= {val_reg[ROOT_VW-3:0], 2'b00};
                if (fits)
                begin
                    rem_reg  <= ROOT_RW'(0) + (ROOT_RW+2)'(rem_sh - trial);
                    root_reg <= {root_reg[ROOT_RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh[ROOT_RW+1:0];
                    root_reg <= {root_reg[ROOT_RW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ROOT_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* rtl/vse_div.sv */
// ----------------------------------------------------------------------------
// vse_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vse_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  vse_pkg::div_req_t          req,
    output logic                       done,
    output logic [vse_pkg::DIV_NW-1:0] quotient
);
    import vse_pkg::*;

    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] dvs_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_DW:0]   rem_sh;
    logic              fits;

    // Shift in the next dividend bit and compare
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DIV_NW-1]};
        fits   = (rem_sh >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                rem_reg  <= '0;
                cnt_reg  <= DIV_CW'(DIV_NW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    rem_reg <= DIV_DW'(rem_sh - {1'b0, dvs_reg});
                end
                else
                begin
                    rem_reg <= rem_sh[DIV_DW-1:0];
                end
                quo_reg <= {quo_reg[DIV_NW-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/vmf_stats_estimate.sv */
// ----------------------------------------------------------------------------
// vmf_stats_estimate
// Mean direction, mean length and kappa estimate of a summed feature vector.
// ----------------------------------------------------------------------------
// Each element is accepted, then squared on the 32x32 multiplier and
// accumulated; the input is not ready while the square is formed. The last
// element closes the run: the square root unit runs, then the shared
// one-bit-per-cycle divider forms norm/obs_count and kappa, then each mean
// element takes a store read and one division plus any output stall. The
// input is not ready while a run is being closed.
module vmf_stats_estimate (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // feature_value[31:0], obs_count[47:32]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // mean_element[15:0], element_index[21:16],
                                   // mean_length[38:22], concentration[70:39]
    output logic [0:0]  m_tuser,   // stats_valid[0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import vse_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_FLUSH, S_CHECK, S_ROOT_GO, S_ROOT_WAIT, S_R_GO, S_R_WAIT,
        S_MUL_SQ, S_MUL_NUM, S_K_GO, S_K_WAIT, S_E_RD, S_E_GO, S_E_WAIT,
        S_E_OUT, S_BAD_OUT
    } state_t;

    state_t             state_reg;
    logic [63:0]        sum_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [15:0]        obs_reg;
    logic [31:0]        mag_reg;
    logic [63:0]        prod_reg;
    logic               pend_reg;
    logic               store_ok_reg;
    logic               last_reg;
    logic [31:0]        norm_reg;
    logic [16:0]        r_reg;
    logic [33:0]        r2_reg;
    logic [33:0]        denom_reg;
    logic [63:0]        num_reg;
    logic [31:0]        kappa_reg;
    logic [31:0]        limit_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               sign_reg;
    logic [15:0]        elem_reg;
    logic               tuser_reg;

    logic               accept;
    logic [31:0]        in_value;
    logic [31:0]        in_mag;
    logic [64:0]        sum_add;
    logic [63:0]        sum_sat;
    logic [31:0]        ram_q;
    logic [31:0]        ram_mag;
    div_req_t           div_req;
    logic               div_done;
    logic [DIV_NW-1:0]  div_q;
    logic               root_start;
    logic               root_done;
    logic [ROOT_RW-1:0] root_val;
    logic [38:0]        num_diff;
    logic               is_last_elem;

    // Handshake and input magnitude
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign in_value  = s_tdata[31:0];
    assign in_mag    = in_value[31] ? (~in_value + 32'd1) : in_value;
    assign ram_mag   = ram_q[31] ? (~ram_q + 32'd1) : ram_q;

    // Saturating accumulate of the pending square
    assign sum_add = {1'b0, sum_reg} + {1'b0, prod_reg};
    assign sum_sat = sum_add[64] ? '1 : sum_add[63:0];

    assign num_diff     = {count_reg, 32'd0} - {5'd0, r2_reg};
    assign is_last_elem = ({1'b0, idx_reg} + CNT_W'(1)) == count_reg;

    vse_ram #(
        .WIDTH (32),
        .DEPTH (MAX_DIM)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept && (count_reg < CNT_W'(MAX_DIM))),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (in_value),
        .rd_en   (state_reg == S_E_RD),
        .rd_addr (idx_reg),
        .rd_data (ram_q)
    );

    assign root_start = (state_reg == S_ROOT_GO);

    vse_root u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (sum_reg),
        .done  (root_done),
        .root  (root_val)
    );

    // Select divider operands for each division
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = {32'd0, norm_reg};
        div_req.divisor  = {17'd0, obs_reg};
        unique case (state_reg)
            S_R_GO:
            begin
                div_req.start = 1'b1;
            end
            S_K_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = num_reg;
                div_req.divisor  = denom_reg[DIV_DW-1:0];
            end
            S_E_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {17'd0, ram_mag, 15'd0};
                div_req.divisor  = {1'b0, norm_reg};
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    vse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            sum_reg      <= '0;
            count_reg    <= '0;
            obs_reg      <= '0;
            mag_reg      <= '0;
            prod_reg     <= '0;
            pend_reg     <= 1'b0;
            store_ok_reg <= 1'b0;
            last_reg     <= 1'b0;
            norm_reg     <= '0;
            r_reg        <= '0;
            r2_reg       <= '0;
            denom_reg    <= '0;
            num_reg      <= '0;
            kappa_reg    <= '0;
            limit_reg    <= LIMIT_RESET;
            idx_reg      <= '0;
            sign_reg     <= 1'b0;
            elem_reg     <= '0;
            tuser_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pend_reg)
                    begin
                        sum_reg  <= sum_sat;
                        pend_reg <= 1'b0;
                    end
                    if (accept)
                    begin
                        mag_reg      <= in_mag;
                        last_reg     <= s_tlast;
                        store_ok_reg <= (count_reg < CNT_W'(MAX_DIM));
                        if (count_reg < CNT_W'(MAX_DIM))
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (s_tlast)
                        begin
                            obs_reg <= s_tdata[47:32];
                        end
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    prod_reg  <= {32'd0, mag_reg} * {32'd0, mag_reg};
                    pend_reg  <= store_ok_reg;
                    state_reg <= last_reg ? S_FLUSH : S_IDLE;
                end
                S_FLUSH:
                begin
                    if (pend_reg)
                    begin
                        sum_reg  <= sum_sat;
                        pend_reg <= 1'b0;
                    end
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    idx_reg <= '0;
                    if ((obs_reg == 16'd0) || (sum_reg == 64'd0) || (count_reg == '0))
                    begin
                        state_reg <= S_BAD_OUT;
                    end
                    else
                    begin
                        state_reg <= S_ROOT_GO;
                    end
                end
                S_ROOT_GO:
                begin
                    state_reg <= S_ROOT_WAIT;
                end
                S_ROOT_WAIT:
                begin
                    if (root_done)
                    begin
                        norm_reg  <= root_val;
                        state_reg <= S_R_GO;
                    end
                end
                S_R_GO:
                begin
                    state_reg <= S_R_WAIT;
                end
                S_R_WAIT:
                begin
                    if (div_done)
                    begin
                        r_reg     <= (div_q > {47'd0, ONE_Q16}) ? ONE_Q16 : div_q[16:0];
                        state_reg <= S_MUL_SQ;
                    end
                end
                S_MUL_SQ:
                begin
                    r2_reg    <= {17'd0, r_reg} * {17'd0, r_reg};
                    state_reg <= S_MUL_NUM;
                end
                S_MUL_NUM:
                begin
                    denom_reg <= 34'h1_0000_0000 - r2_reg;
                    num_reg   <= 64'({48'd0, r_reg[15:0]} * {25'd0, num_diff});
                    if ((obs_reg <= 16'd1) || (r2_reg == 34'h1_0000_0000))
                    begin
                        kappa_reg <= limit_reg;
                        state_reg <= S_E_RD;
                    end
                    else
                    begin
                        state_reg <= S_K_GO;
                    end
                end
                S_K_GO:
                begin
                    state_reg <= S_K_WAIT;
                end
                S_K_WAIT:
                begin
                    if (div_done)
                    begin
                        kappa_reg <= (div_q > {32'd0, limit_reg}) ? limit_reg : div_q[31:0];
                        state_reg <= S_E_RD;
                    end
                end
                S_E_RD:
                begin
                    state_reg <= S_E_GO;
                end
                S_E_GO:
                begin
                    sign_reg  <= ram_q[31];
                    state_reg <= S_E_WAIT;
                end
                S_E_WAIT:
                begin
                    if (div_done)
                    begin
                        if (sign_reg)
                        begin
                            elem_reg <= (div_q > {47'd0, NEG_SAT}) ? 16'h8000
                                                                   : (16'd0 - div_q[15:0]);
                        end
                        else
                        begin
                            elem_reg <= (div_q > {48'd0, POS_SAT}) ? POS_SAT : div_q[15:0];
                        end
                        tuser_reg <= 1'b1;
                        state_reg <= S_E_OUT;
                    end
                end
                S_E_OUT:
                begin
                    if (m_tready)
                    begin
                        if (is_last_elem)
                        begin
                            sum_reg   <= '0;
                            count_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_E_RD;
                        end
                    end
                end
                S_BAD_OUT:
                begin
                    tuser_reg <= 1'b0;
                    if (m_tready)
                    begin
                        sum_reg   <= '0;
                        count_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output transaction
    always_comb
    begin
        m_tvalid = (state_reg == S_E_OUT) || (state_reg == S_BAD_OUT);
        if (state_reg == S_BAD_OUT)
        begin
            m_tdata = '0;
            m_tuser = 1'b0;
            m_tlast = 1'b1;
        end
        else
        begin
            m_tdata = {1'b0, kappa_reg, r_reg, idx_reg, elem_reg};
            m_tuser = tuser_reg;
            m_tlast = is_last_elem;
        end
    end

`ifndef NO_ASSERTIONS
    // Input and output never open at the same time
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // Store fill never passes its depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(MAX_DIM))
        else $error("element count beyond store depth");

    // An invalid result always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("invalid result not marked last");

    // Counters clear after the final transaction of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (count_reg == '0 && sum_reg == 64'd0))
        else $error("run state not cleared");
`endif

endmodule
